@@ rtl/otpcv_pkg.sv @@
// Shared types, constants and register map of the calibration image validator.
package otpcv_pkg;

    localparam int IMAGE_BYTES_DEF = 7233;
    localparam int OFFSET_W = 13;
    localparam int ADDR_W = 4;
    localparam int DEV_W = 24;
    localparam int WORD_W = 16;
    localparam int SQ_W = 2 * WORD_W;
    localparam int SCALE_SH = 20;
    localparam int QUO_W = SQ_W + SCALE_SH;
    localparam int ACC_W = QUO_W + 2;
    localparam int CNT_W = 6;
    localparam int CHAN_W = 2;

    localparam logic [OFFSET_W-1:0] VENDOR_POS = 13'h0001;
    localparam logic [OFFSET_W-1:0] BAL_START  = 13'h0cac;
    localparam logic [OFFSET_W-1:0] BAL_END    = 13'h0cb7;

    localparam logic [OFFSET_W-1:0] HEAD0 = 13'h0000;
    localparam logic [OFFSET_W-1:0] HEAD1 = 13'h0020;
    localparam logic [OFFSET_W-1:0] HEAD2 = 13'h0045;
    localparam logic [OFFSET_W-1:0] HEAD3 = 13'h0cab;
    localparam logic [OFFSET_W-1:0] HEAD4 = 13'h0ce1;
    localparam logic [OFFSET_W-1:0] HEAD5 = 13'h143f;
    localparam logic [OFFSET_W-1:0] TAIL0 = 13'h001f;
    localparam logic [OFFSET_W-1:0] TAIL1 = 13'h0044;
    localparam logic [OFFSET_W-1:0] TAIL2 = 13'h0065;
    localparam logic [OFFSET_W-1:0] TAIL3 = 13'h0ce0;
    localparam logic [OFFSET_W-1:0] TAIL4 = 13'h143e;
    localparam logic [OFFSET_W-1:0] TAIL5 = 13'h1c40;

    localparam logic [DEV_W-1:0] DEV_MAX = 24'hFFFFFF;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);
    localparam logic [CHAN_W-1:0] CHAN_LAST = 2'd2;

    localparam logic [7:0] VENDOR_RST = 8'd1;
    localparam logic [7:0] FLAG_RST = 8'd1;
    localparam logic [DEV_W-1:0] LIMIT_RST = 24'd10485;

    typedef enum logic [1:0] {
        REG_VENDOR = 2'd0,
        REG_FLAG   = 2'd1,
        REG_LIMIT  = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ERR_OK     = 3'd0,
        ERR_GROUP  = 3'd1,
        ERR_VENDOR = 3'd2,
        ERR_SUM    = 3'd3,
        ERR_AWB    = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECV,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_ACC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic take;
        logic eval;
        logic mul;
        logic div;
        logic acc;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic at_last;
        logic last_pos;
        logic bad;
        logic gzero;
        logic div_done;
        logic chan_last;
        logic out_pending;
    } t_status;

endpackage

@@ rtl/otp_calibration_validator_core.sv @@
// Top level of the calibration image validator: register port, sequencer and datapath.
//
//   Channel   Direction  Handshake          Payload
//   input     in         i_valid / o_ready  i_data_byte, i_first
//   result    out        o_valid / i_ready  o_pass, o_error_code, o_awb_deviation
//   config    in         psel / penable     paddr, pwrite, pwdata, prdata, pready
//
// While an image is received, the intake runs at one request per clock.
// After the last byte, the check goes straight to the result when a flag, vendor or
// checksum test failed or a golden word is zero; otherwise it first runs three channels
// in turn, each a square, a 52-step restoring divider and an accumulate.
// Reset is synchronous and active low; it restores the register defaults and leaves the
// block waiting for a byte marked first.
// A result waits in its output register; bytes keep flowing while it waits, and only
// the last byte of the next image is held back until the result has been taken.
module otp_calibration_validator_core #(
    parameter int IMAGE_BYTES = otpcv_pkg::IMAGE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_first,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_pass,
    output logic [2:0]                    o_error_code,
    output logic [otpcv_pkg::DEV_W-1:0]   o_awb_deviation,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [otpcv_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import otpcv_pkg::*;

    logic [7:0]       r_expected_vendor;
    logic [7:0]       r_valid_flag_value;
    logic [DEV_W-1:0] r_awb_limit;
    logic             cfg_write;
    t_reg_idx         reg_idx;
    t_cmd             cmd;
    t_status          status;

    // The register file is written in the access phase of a write request.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_vendor  <= VENDOR_RST;
            r_valid_flag_value <= FLAG_RST;
            r_awb_limit        <= LIMIT_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_VENDOR: r_expected_vendor <= pwdata[7:0];
                REG_FLAG:   r_valid_flag_value <= pwdata[7:0];
                REG_LIMIT:  r_awb_limit <= pwdata[DEV_W-1:0];
                default:    r_awb_limit <= r_awb_limit;
            endcase
        end
    end

    // Reads outside the register list return zero.
    always_comb begin
        case (reg_idx)
            REG_VENDOR: prdata = {24'd0, r_expected_vendor};
            REG_FLAG:   prdata = {24'd0, r_valid_flag_value};
            REG_LIMIT:  prdata = {8'd0, r_awb_limit};
            default:    prdata = '0;
        endcase
    end

    otpcv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_first  (i_first),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    otpcv_dp #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_data_byte        (i_data_byte),
        .i_first            (i_first),
        .i_expected_vendor  (r_expected_vendor),
        .i_valid_flag_value (r_valid_flag_value),
        .i_awb_limit        (r_awb_limit),
        .i_out_take         (i_ready),
        .o_status           (status),
        .o_valid            (o_valid),
        .o_pass             (o_pass),
        .o_error_code       (o_error_code),
        .o_awb_deviation    (o_awb_deviation)
    );

endmodule

@@ rtl/otpcv_ctrl.sv @@
// Sequencer of the validator: byte intake, deviation steps and result hand-off.
module otpcv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_first,
    input  otpcv_pkg::t_status i_status,
    output logic               o_ready,
    output otpcv_pkg::t_cmd    o_cmd
);
    import otpcv_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ready = (r_state == S_IDLE) ||
                  ((r_state == S_RECV) && !(i_status.last_pos && i_status.out_pending));
        take = i_valid && o_ready && (i_first || (r_state == S_RECV));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) n_state = S_RECV;
            end
            S_RECV: begin
                if (take && i_status.at_last) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = (i_status.bad || i_status.gzero) ? S_FIN : S_MUL;
            end
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) n_state = S_ACC;
            end
            S_ACC: begin
                n_state = i_status.chan_last ? S_FIN : S_MUL;
            end
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.take = take;
        case (r_state)
            S_EVAL:  o_cmd.eval = 1'b1;
            S_MUL:   o_cmd.mul = 1'b1;
            S_DIV:   o_cmd.div = 1'b1;
            S_ACC:   o_cmd.acc = 1'b1;
            S_FIN:   o_cmd.fin = 1'b1;
            default: o_cmd.eval = 1'b0;
        endcase
    end

endmodule

@@ rtl/otpcv_dp.sv @@
// Datapath of the validator: byte checks, balance words, serial divider, result register.
module otpcv_dp #(
    parameter int IMAGE_BYTES = otpcv_pkg::IMAGE_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  otpcv_pkg::t_cmd              i_cmd,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_first,
    input  logic [7:0]                   i_expected_vendor,
    input  logic [7:0]                   i_valid_flag_value,
    input  logic [otpcv_pkg::DEV_W-1:0]  i_awb_limit,
    input  logic                         i_out_take,
    output otpcv_pkg::t_status           o_status,
    output logic                         o_valid,
    output logic                         o_pass,
    output logic [2:0]                   o_error_code,
    output logic [otpcv_pkg::DEV_W-1:0]  o_awb_deviation
);
    import otpcv_pkg::*;

    localparam logic [OFFSET_W-1:0] LAST_POS = OFFSET_W'(IMAGE_BYTES - 1);

    logic [OFFSET_W-1:0] r_offset;
    logic [7:0]          r_sum;
    logic                r_flag_bad;
    logic                r_vendor_bad;
    logic                r_sum_bad;
    logic [WORD_W-1:0]   r_words [6];
    logic                r_gzero;
    logic [SQ_W-1:0]     r_den;
    logic [SQ_W-1:0]     r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic [CHAN_W-1:0]   r_chan;
    logic [ACC_W-1:0]    r_acc;
    logic                r_out_valid;
    logic                r_pass;
    t_err                r_code;
    logic [DEV_W-1:0]    r_dev;

    logic [OFFSET_W-1:0] pos;
    logic [OFFSET_W-1:0] rel;
    logic [7:0]          sum_base;
    logic [8:0]          sum_wide;
    logic [7:0]          sum_add;
    logic                is_head;
    logic                is_flag;
    logic                is_body;
    logic                is_tail;
    logic                is_bal;
    logic [WORD_W-1:0]   diff;
    logic [SQ_W-1:0]     dsq;
    logic [SQ_W-1:0]     gsq;
    logic [SQ_W:0]       trial;
    logic [SQ_W:0]       trial_sub;
    logic                trial_ge;
    t_err                fin_code;
    logic [DEV_W-1:0]    fin_dev;

    always_comb begin
        pos      = i_first ? '0 : r_offset;
        sum_base = i_first ? 8'd0 : r_sum;
        sum_wide = {1'b0, sum_base} + {1'b0, i_data_byte};
        sum_add  = (sum_wide >= 9'd255) ? 8'(sum_wide - 9'd255) : sum_wide[7:0];
        is_flag  = (pos == HEAD0) || (pos == HEAD1) || (pos == HEAD2) ||
                   (pos == HEAD3) || (pos == HEAD4);
        is_head  = is_flag || (pos == HEAD5);
        is_tail  = (pos == TAIL0) || (pos == TAIL1) || (pos == TAIL2) ||
                   (pos == TAIL3) || (pos == TAIL4) || (pos == TAIL5);
        is_body  = ((pos > HEAD0) && (pos < TAIL0)) || ((pos > HEAD1) && (pos < TAIL1)) ||
                   ((pos > HEAD2) && (pos < TAIL2)) || ((pos > HEAD3) && (pos < TAIL3)) ||
                   ((pos > HEAD4) && (pos < TAIL4)) || ((pos > HEAD5) && (pos < TAIL5));
        is_bal   = (pos >= BAL_START) && (pos <= BAL_END);
        rel      = pos - BAL_START;
    end

    // Byte intake: offset, region sums and sticky check flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= '0;
            r_sum        <= '0;
            r_flag_bad   <= 1'b0;
            r_vendor_bad <= 1'b0;
            r_sum_bad    <= 1'b0;
        end else if (i_cmd.take) begin
            r_offset <= (pos < LAST_POS) ? pos + 1'b1 : pos;
            if (is_head) begin
                r_sum <= 8'd0;
            end else if (is_body) begin
                r_sum <= sum_add;
            end else begin
                r_sum <= sum_base;
            end
            r_flag_bad   <= (i_first ? 1'b0 : r_flag_bad) |
                            (is_flag && (i_data_byte != i_valid_flag_value));
            r_vendor_bad <= (i_first ? 1'b0 : r_vendor_bad) |
                            ((pos == VENDOR_POS) && (i_data_byte != i_expected_vendor));
            r_sum_bad    <= (i_first ? 1'b0 : r_sum_bad) |
                            (is_tail && ({1'b0, i_data_byte} != ({1'b0, sum_base} + 9'd1)));
        end
    end

    // Balance words: byte writes during intake, rotation between channels so that
    // the unit word sits at entry 0 and the golden word at entry 3.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_bal) begin
            for (int k = 0; k < 6; k++) begin
                if (rel[3:1] == 3'(k)) begin
                    if (rel[0]) begin
                        r_words[k][7:0] <= i_data_byte;
                    end else begin
                        r_words[k][15:8] <= i_data_byte;
                    end
                end
            end
        end else if (i_cmd.acc) begin
            r_words[0] <= r_words[1];
            r_words[1] <= r_words[2];
            r_words[2] <= r_words[0];
            r_words[3] <= r_words[4];
            r_words[4] <= r_words[5];
            r_words[5] <= r_words[3];
        end
    end

    always_comb begin
        diff      = (r_words[0] > r_words[3]) ? r_words[0] - r_words[3]
                                              : r_words[3] - r_words[0];
        dsq       = {16'd0, diff} * {16'd0, diff};
        gsq       = {16'd0, r_words[3]} * {16'd0, r_words[3]};
        trial     = {r_rem, r_quo[QUO_W-1]};
        trial_sub = trial - {1'b0, r_den};
        trial_ge  = (trial >= {1'b0, r_den});
    end

    // Squares, restoring divider (one quotient bit a cycle) and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_chan <= '0;
        end else if (i_cmd.eval) begin
            r_chan <= '0;
        end else if (i_cmd.mul) begin
            r_cnt <= '0;
        end else if (i_cmd.div) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.acc) begin
            r_chan <= r_chan + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_acc   <= '0;
            r_gzero <= (r_words[3] == '0) || (r_words[4] == '0) || (r_words[5] == '0);
        end
        if (i_cmd.mul) begin
            r_quo <= {dsq, {SCALE_SH{1'b0}}};
            r_den <= gsq;
            r_rem <= '0;
        end else if (i_cmd.div) begin
            r_quo <= {r_quo[QUO_W-2:0], trial_ge};
            r_rem <= trial_ge ? trial_sub[SQ_W-1:0] : trial[SQ_W-1:0];
        end
        if (i_cmd.acc) begin
            r_acc <= r_acc + {2'b00, r_quo};
        end
    end

    always_comb begin
        fin_dev = '0;
        if (r_flag_bad) begin
            fin_code = ERR_GROUP;
        end else if (r_vendor_bad) begin
            fin_code = ERR_VENDOR;
        end else if (r_sum_bad) begin
            fin_code = ERR_SUM;
        end else if (r_gzero) begin
            fin_code = ERR_AWB;
            fin_dev  = DEV_MAX;
        end else begin
            fin_code = (r_acc > {{(ACC_W-DEV_W){1'b0}}, i_awb_limit}) ? ERR_AWB : ERR_OK;
            fin_dev  = (r_acc > {{(ACC_W-DEV_W){1'b0}}, DEV_MAX}) ? DEV_MAX
                                                                   : r_acc[DEV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_code <= fin_code;
            r_pass <= (fin_code == ERR_OK);
            r_dev  <= fin_dev;
        end
    end

    always_comb begin
        o_status.at_last     = (pos == LAST_POS);
        o_status.last_pos    = (r_offset == LAST_POS);
        o_status.bad         = r_flag_bad || r_vendor_bad || r_sum_bad;
        o_status.gzero       = (r_words[3] == '0) || (r_words[4] == '0) || (r_words[5] == '0);
        o_status.div_done    = (r_cnt == DIV_LAST);
        o_status.chan_last   = (r_chan == CHAN_LAST);
        o_status.out_pending = r_out_valid;
        o_valid              = r_out_valid;
        o_pass               = r_pass;
        o_error_code         = r_code;
        o_awb_deviation      = r_dev;
    end

endmodule

@@ rtl/otpcv_checker.sv @@
// Port-level checks of the validator, bound to its top level.
module otpcv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_pass,
    input logic [2:0]  o_error_code,
    input logic [23:0] o_awb_deviation
);
    import otpcv_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_error_code) && $stable(o_awb_deviation))
        else $error("result changed while stalled");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pass == (o_error_code == ERR_OK)))
        else $error("pass disagrees with error code");

    a_nodev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_error_code == ERR_GROUP || o_error_code == ERR_VENDOR ||
                    o_error_code == ERR_SUM) |-> (o_awb_deviation == '0))
        else $error("deviation reported for an early failure");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_code <= ERR_AWB))
        else $error("error code out of range");

endmodule

bind otp_calibration_validator_core otpcv_checker u_otpcv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_pass          (o_pass),
    .o_error_code    (o_error_code),
    .o_awb_deviation (o_awb_deviation)
);
